@@ src/atc_pkg.sv @@
`timescale 1ns / 1ps
// shared widths, constants and control structs for the target calculation core
// no dependencies
package atc_pkg;

  localparam int unsigned TARGET_BITS_DEF = 224;
  localparam int unsigned MAX_TARGET_BITS = 224;
  localparam int unsigned WORD_W          = 56;
  localparam int unsigned ET_W            = 49;
  localparam int unsigned H_W             = 31;
  localparam int unsigned SPC_W           = 31;
  localparam int unsigned HL_W            = 32;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 56;
  localparam int unsigned IN_TDATA_W      = 304;
  localparam int unsigned OUT_TDATA_W     = 224;
  localparam int unsigned DIFF_W          = 64;
  localparam int unsigned MAG_W           = 48;
  localparam int unsigned DIV_W           = 64;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned FACTOR_W        = 17;
  localparam int unsigned SH_W            = 51;
  localparam int unsigned LIMB_W          = 32;

  localparam logic [63:0] POLY_C1    = 64'd195766423245049;
  localparam logic [63:0] POLY_C2    = 64'd971821376;
  localparam logic [63:0] POLY_C3    = 64'd5127;
  localparam logic [63:0] POLY_ROUND = 64'h0000_8000_0000_0000;
  localparam logic [63:0] DRIFT_LIM  = 64'h0000_8000_0000_0000;
  localparam logic [16:0] FACTOR_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPACING   = 3'd0,
    CFG_HALF_LIFE = 3'd1,
    CFG_LIMIT0    = 3'd2,
    CFG_LIMIT1    = 3'd3,
    CFG_LIMIT2    = 3'd4,
    CFG_LIMIT3    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic bad;
    logic neg;
  } atc_ctl_t;

  typedef struct packed {
    logic valid;
    logic bad;
    logic sh_high;
    logic sh_low;
  } atc_sel_t;

endpackage

@@ src/asert_target_calculation_core.sv @@
`timescale 1ns / 1ps
// top level of the target calculation core: config registers, stream ports, stage chain
// depends on atc_pkg, atc_front, atc_div, atc_expo, atc_scale
//
//  channel   | direction | handshake                  | contents
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | anchor target, elapsed time, blocks
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | new target, bad input flag
//  cfg       | in        | cfg_we_i (no back-pressure) | spacing, half life, limit words
//
// one word accepted per cycle while the output word is not held; the chain is the 64 stages of the
// bit-per-stage divider plus 15 stages of checks, polynomial, multiply and shift.
// reset clears the valid bits and loads the default configuration.
// a stalled output word freezes the whole chain; nothing is dropped or repeated.
module asert_target_calculation_core #(
  parameter int unsigned TargetBits = atc_pkg::TARGET_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [atc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [atc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // anchor_word0, anchor_word1, anchor_word2, anchor_word3, elapsed_time, blocks_since_anchor
  input  logic [atc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // result_word0, result_word1, result_word2, result_word3
  output logic [atc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // bad_input
  output logic                               m_axis_tuser
);

  localparam int unsigned WW = atc_pkg::WORD_W;
  localparam int unsigned PW = TargetBits + atc_pkg::FACTOR_W;
  localparam int unsigned AW = $clog2(TargetBits + PW);
  localparam int unsigned SideW = TargetBits + 2;

  logic [atc_pkg::SPC_W-1:0] spacing_q;
  logic [atc_pkg::HL_W-1:0]  half_life_q;
  logic [WW-1:0] lim0_q, lim1_q, lim2_q, lim3_q;
  logic [atc_pkg::MAX_TARGET_BITS-1:0] lim_full, anc_full;
  logic [TargetBits-1:0] limit;

  logic en;
  atc_pkg::atc_ctl_t front_ctl, div_ctl;
  logic [TargetBits-1:0] front_anc, div_anc, expo_anc, res;
  logic [atc_pkg::MAG_W-1:0] front_mag;
  logic [SideW-1:0] div_side;
  logic div_valid;
  logic [atc_pkg::DIV_W-1:0] quo;
  atc_pkg::atc_sel_t expo_sel;
  logic [AW-1:0] expo_amt;
  logic [atc_pkg::FACTOR_W-1:0] expo_factor;
  logic out_valid, out_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= atc_pkg::SPC_W'(600);
      half_life_q <= atc_pkg::HL_W'(172800);
      lim0_q      <= '1;
      lim1_q      <= '1;
      lim2_q      <= '1;
      lim3_q      <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atc_pkg::CFG_SPACING:   spacing_q   <= cfg_wdata_i[atc_pkg::SPC_W-1:0];
        atc_pkg::CFG_HALF_LIFE: half_life_q <= cfg_wdata_i[atc_pkg::HL_W-1:0];
        atc_pkg::CFG_LIMIT0:    lim0_q      <= cfg_wdata_i[WW-1:0];
        atc_pkg::CFG_LIMIT1:    lim1_q      <= cfg_wdata_i[WW-1:0];
        atc_pkg::CFG_LIMIT2:    lim2_q      <= cfg_wdata_i[WW-1:0];
        atc_pkg::CFG_LIMIT3:    lim3_q      <= cfg_wdata_i[WW-1:0];
        default: ;
      endcase
    end
  end

  assign lim_full = {lim3_q, lim2_q, lim1_q, lim0_q};
  assign limit    = lim_full[TargetBits-1:0];
  assign anc_full = s_axis_tdata[atc_pkg::MAX_TARGET_BITS-1:0];

  // chain advances unless the output word is held
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  atc_front #(.TargetBits(TargetBits)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .anchor_i    (anc_full[TargetBits-1:0]),
    .elapsed_i   (s_axis_tdata[272:224]),
    .blocks_i    (s_axis_tdata[303:273]),
    .spacing_i   (spacing_q),
    .half_life_i (half_life_q),
    .limit_i     (limit),
    .ctl_o       (front_ctl),
    .anchor_o    (front_anc),
    .mag_o       (front_mag)
  );

  atc_div #(.SideW(SideW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_ctl.valid),
    .side_i  ({front_anc, front_ctl.bad, front_ctl.neg}),
    .num_i   ({front_mag, {atc_pkg::FRAC_W{1'b0}}}),
    .den_i   (half_life_q),
    .valid_o (div_valid),
    .side_o  (div_side),
    .quo_o   (quo)
  );

  assign div_anc = div_side[SideW-1:2];
  assign div_ctl = '{valid: div_valid, bad: div_side[1], neg: div_side[0]};

  atc_expo #(.TargetBits(TargetBits)) u_expo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (div_ctl),
    .quo_i    (quo),
    .anchor_i (div_anc),
    .sel_o    (expo_sel),
    .amt_o    (expo_amt),
    .factor_o (expo_factor),
    .anchor_o (expo_anc)
  );

  atc_scale #(.TargetBits(TargetBits)) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .sel_i    (expo_sel),
    .amt_i    (expo_amt),
    .factor_i (expo_factor),
    .anchor_i (expo_anc),
    .limit_i  (limit),
    .valid_o  (out_valid),
    .bad_o    (out_bad),
    .result_o (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_bad;
  assign m_axis_tdata  = atc_pkg::OUT_TDATA_W'(res);

  // a held output freezes the early stages too
  a_front_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(front_ctl.valid) && $stable(front_mag))
    else $error("front stage moved during a stall");

  // shift classes exclude each other
  a_shift_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expo_sel.valid |-> !(expo_sel.sh_high && expo_sel.sh_low))
    else $error("shift amount both above and below range");

  // the factor is always in [1.0, 2.0)
  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expo_sel.valid |-> expo_factor[atc_pkg::FACTOR_W-1])
    else $error("2^x factor out of range");

endmodule

@@ src/atc_front.sv @@
`timescale 1ns / 1ps
// input capture, drift computation and input checks (five stages)
// depends on atc_pkg
module atc_front #(
  parameter int unsigned TargetBits = atc_pkg::TARGET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [TargetBits-1:0]         anchor_i,
  input  logic [atc_pkg::ET_W-1:0]      elapsed_i,
  input  logic [atc_pkg::H_W-1:0]       blocks_i,
  input  logic [atc_pkg::SPC_W-1:0]     spacing_i,
  input  logic [atc_pkg::HL_W-1:0]      half_life_i,
  input  logic [TargetBits-1:0]         limit_i,
  output atc_pkg::atc_ctl_t             ctl_o,
  output logic [TargetBits-1:0]         anchor_o,
  output logic [atc_pkg::MAG_W-1:0]     mag_o
);

  localparam int unsigned DW = atc_pkg::DIFF_W;

  logic [4:0] vld_q;

  logic [TargetBits-1:0] anc0_q, anc1_q, anc2_q, anc3_q, anc4_q;
  logic [atc_pkg::ET_W-1:0] et0_q, et1_q;
  logic [atc_pkg::H_W-1:0] h0_q;
  logic [atc_pkg::SPC_W+atc_pkg::H_W-1:0] prod1_d, prod1_q;
  logic bad1_d, bad1_q, bad2_q, bad3_d, bad3_q, bad4_q;
  logic [DW-1:0] d2_d, d2_q, e3_d, e3_q;
  logic [DW-1:0] mag_full;
  logic neg4_q;
  logic [atc_pkg::MAG_W-1:0] mag4_q;

  assign prod1_d = h0_q * spacing_i;
  assign bad1_d  = (anc0_q == '0) || (anc0_q > limit_i) || (spacing_i == '0) ||
                   (half_life_i == '0);
  assign d2_d    = {{(DW-atc_pkg::ET_W){et1_q[atc_pkg::ET_W-1]}}, et1_q} - DW'(prod1_q);
  // drift must stay strictly inside +-2^47
  assign bad3_d  = bad2_q || ($signed(d2_q) >= $signed(atc_pkg::DRIFT_LIM)) ||
                   ($signed(d2_q) <= -$signed(atc_pkg::DRIFT_LIM));
  assign e3_d    = d2_q - DW'(spacing_i);
  assign mag_full = e3_q[DW-1] ? (~e3_q + DW'(1)) : e3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      anc0_q  <= anchor_i;
      et0_q   <= elapsed_i;
      h0_q    <= blocks_i;
      anc1_q  <= anc0_q;
      et1_q   <= et0_q;
      prod1_q <= prod1_d;
      bad1_q  <= bad1_d;
      anc2_q  <= anc1_q;
      d2_q    <= d2_d;
      bad2_q  <= bad1_q;
      anc3_q  <= anc2_q;
      e3_q    <= e3_d;
      bad3_q  <= bad3_d;
      anc4_q  <= anc3_q;
      neg4_q  <= e3_q[DW-1];
      mag4_q  <= mag_full[atc_pkg::MAG_W-1:0];
      bad4_q  <= bad3_q;
    end
  end

  assign ctl_o    = '{valid: vld_q[4], bad: bad4_q, neg: neg4_q};
  assign anchor_o = anc4_q;
  assign mag_o    = mag4_q;

endmodule

@@ src/atc_div.sv @@
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, side data carried along
// depends on atc_pkg
module atc_div #(
  parameter int unsigned SideW = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [SideW-1:0]            side_i,
  input  logic [atc_pkg::DIV_W-1:0]   num_i,
  input  logic [atc_pkg::HL_W-1:0]    den_i,
  output logic                        valid_o,
  output logic [SideW-1:0]            side_o,
  output logic [atc_pkg::DIV_W-1:0]   quo_o
);

  localparam int unsigned Steps = atc_pkg::DIV_W;
  localparam int unsigned RW    = atc_pkg::HL_W;
  localparam int unsigned AccW  = RW + Steps;

  logic [Steps-1:0] vld_q;
  logic [AccW-1:0]  acc_q  [Steps];
  logic [SideW-1:0] side_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [AccW-1:0]  acc_in;
    logic [SideW-1:0] side_in;
    logic [RW:0]      trial;
    logic             ge;
    logic [RW-1:0]    rem_nx;

    if (k == 0) begin : g_first
      assign acc_in  = {{RW{1'b0}}, num_i};
      assign side_in = side_i;
    end else begin : g_next
      assign acc_in  = acc_q[k-1];
      assign side_in = side_q[k-1];
    end

    // partial remainder with the next numerator bit shifted in
    assign trial  = acc_in[AccW-1:Steps-1];
    assign ge     = trial >= {1'b0, den_i};
    assign rem_nx = ge ? RW'(trial - {1'b0, den_i}) : trial[RW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]  <= {rem_nx, acc_in[Steps-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign side_o  = side_q[Steps-1];
  assign quo_o   = acc_q[Steps-1][Steps-1:0];

endmodule

@@ src/atc_expo.sv @@
`timescale 1ns / 1ps
// exponent split, shift classification and cubic 2^x factor (five stages)
// depends on atc_pkg
module atc_expo #(
  parameter int unsigned TargetBits = atc_pkg::TARGET_BITS_DEF,
  localparam int unsigned PW = TargetBits + atc_pkg::FACTOR_W,
  localparam int unsigned AW = $clog2(TargetBits + PW)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  atc_pkg::atc_ctl_t             ctl_i,
  input  logic [atc_pkg::DIV_W-1:0]     quo_i,
  input  logic [TargetBits-1:0]         anchor_i,
  output atc_pkg::atc_sel_t             sel_o,
  output logic [AW-1:0]                 amt_o,
  output logic [atc_pkg::FACTOR_W-1:0]  factor_o,
  output logic [TargetBits-1:0]         anchor_o
);

  localparam int unsigned SW = atc_pkg::SH_W;
  localparam int unsigned FW = atc_pkg::FRAC_W;
  localparam logic signed [SW-1:0] ShHigh = SW'(TargetBits);
  localparam logic signed [SW-1:0] ShLow  = -SW'(PW);

  logic [4:0] vld_q;
  logic [TargetBits-1:0] anc1_q, anc2_q, anc3_q, anc4_q, anc5_q;
  logic bad1_q, bad2_q, bad3_q, bad4_q, bad5_q;
  logic hi2_q, hi3_q, hi4_q, hi5_q, lo2_q, lo3_q, lo4_q, lo5_q;
  logic [AW-1:0] amt2_q, amt3_q, amt4_q, amt5_q;

  // stage 1 signals
  logic [SW-1:0] qi_ext, shf, sh_d;
  logic [FW-1:0] qf, frac_d;
  logic          fz;
  logic signed [SW-1:0] sh1_q;
  logic [FW-1:0] frac1_q;

  // polynomial terms
  logic [63:0] p1_q, p1b_q, c2f2_q, c3f3_q, s1_q, s_sum;
  logic [31:0] f2_q;
  logic [FW-1:0] frac2_q;
  logic [47:0] f3_q;
  logic [atc_pkg::FACTOR_W-1:0] factor5_q;

  assign qi_ext = SW'(quo_i[atc_pkg::DIV_W-1:FW]);
  assign qf     = quo_i[FW-1:0];
  assign fz     = (qf == '0);
  // floor of a negative exponent: -q or -q-1 when a fraction remains
  assign shf    = ctl_i.neg ? (~qi_ext + SW'(fz)) : qi_ext;
  assign sh_d   = shf - SW'(16);
  assign frac_d = (ctl_i.neg && !fz) ? FW'(17'h10000 - {1'b0, qf}) : qf;

  assign s_sum  = s1_q + c3f3_q + atc_pkg::POLY_ROUND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1
      anc1_q  <= anchor_i;
      bad1_q  <= ctl_i.bad;
      sh1_q   <= sh_d;
      frac1_q <= frac_d;
      // stage 2
      anc2_q  <= anc1_q;
      bad2_q  <= bad1_q;
      hi2_q   <= sh1_q >= ShHigh;
      lo2_q   <= sh1_q <= ShLow;
      amt2_q  <= AW'(SW'(TargetBits) - sh1_q);
      p1_q    <= atc_pkg::POLY_C1 * 64'(frac1_q);
      f2_q    <= 32'(frac1_q) * 32'(frac1_q);
      frac2_q <= frac1_q;
      // stage 3
      anc3_q  <= anc2_q;
      bad3_q  <= bad2_q;
      hi3_q   <= hi2_q;
      lo3_q   <= lo2_q;
      amt3_q  <= amt2_q;
      p1b_q   <= p1_q;
      c2f2_q  <= atc_pkg::POLY_C2 * 64'(f2_q);
      f3_q    <= 48'(f2_q) * 48'(frac2_q);
      // stage 4
      anc4_q  <= anc3_q;
      bad4_q  <= bad3_q;
      hi4_q   <= hi3_q;
      lo4_q   <= lo3_q;
      amt4_q  <= amt3_q;
      c3f3_q  <= atc_pkg::POLY_C3 * 64'(f3_q);
      s1_q    <= p1b_q + c2f2_q;
      // stage 5
      anc5_q    <= anc4_q;
      bad5_q    <= bad4_q;
      hi5_q     <= hi4_q;
      lo5_q     <= lo4_q;
      amt5_q    <= amt4_q;
      factor5_q <= atc_pkg::FACTOR_ONE + 17'(s_sum[63:48]);
    end
  end

  assign sel_o    = '{valid: vld_q[4], bad: bad5_q, sh_high: hi5_q, sh_low: lo5_q};
  assign amt_o    = amt5_q;
  assign factor_o = factor5_q;
  assign anchor_o = anc5_q;

endmodule

@@ src/atc_scale.sv @@
`timescale 1ns / 1ps
// target times factor, two-step shift, limit clamp and zero fix-up (five stages)
// depends on atc_pkg
module atc_scale #(
  parameter int unsigned TargetBits = atc_pkg::TARGET_BITS_DEF,
  localparam int unsigned PW = TargetBits + atc_pkg::FACTOR_W,
  localparam int unsigned AW = $clog2(TargetBits + PW)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  atc_pkg::atc_sel_t             sel_i,
  input  logic [AW-1:0]                 amt_i,
  input  logic [atc_pkg::FACTOR_W-1:0]  factor_i,
  input  logic [TargetBits-1:0]         anchor_i,
  input  logic [TargetBits-1:0]         limit_i,
  output logic                          valid_o,
  output logic                          bad_o,
  output logic [TargetBits-1:0]         result_o
);

  localparam int unsigned LW   = atc_pkg::LIMB_W;
  localparam int unsigned NCH  = (TargetBits + LW - 1) / LW;
  localparam int unsigned ExtW = NCH * LW;
  localparam int unsigned PPW  = LW + atc_pkg::FACTOR_W;
  localparam int unsigned SumW = ExtW + 2 * LW;
  localparam int unsigned WW   = TargetBits + PW;

  logic [4:0] vld_q;

  logic [ExtW-1:0] anc_ext;
  logic [PPW-1:0]  pp_d [NCH];
  logic [PPW-1:0]  pp_q [NCH];
  logic [SumW-1:0] even_v, odd_v, sum_v;
  logic [PW-1:0]   prod_q;
  logic [WW-1:0]   wide_v, crs_q, fine_q;
  logic [AW-1:0]   amt6_q, amt7_q, amt8_q;
  atc_pkg::atc_sel_t s6_q, s7_q, s8_q, s9_q;
  logic            over;
  logic [TargetBits-1:0] res_d, res_q;
  logic            bad_q;

  assign anc_ext = ExtW'(anchor_i);

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      pp_d[k] = PPW'(anc_ext[k*LW +: LW]) * PPW'(factor_i);
    end
  end

  // even and odd limb products do not overlap, so two rows and one add
  always_comb begin
    even_v = '0;
    odd_v  = '0;
    for (int k = 0; k < NCH; k++) begin
      if (k % 2 == 0) begin
        even_v[k*LW +: 2*LW] = (2*LW)'(pp_q[k]);
      end else begin
        odd_v[k*LW +: 2*LW]  = (2*LW)'(pp_q[k]);
      end
    end
    sum_v = even_v + odd_v;
  end

  // product placed TargetBits up, then one right shift covers both directions
  assign wide_v = {prod_q, {TargetBits{1'b0}}};

  assign over = (|fine_q[WW-1:TargetBits]) || (fine_q[TargetBits-1:0] > limit_i);

  always_comb begin
    if (s9_q.bad || s9_q.sh_high) begin
      res_d = limit_i;
    end else if (s9_q.sh_low || fine_q == '0) begin
      res_d = TargetBits'(1);
    end else if (over) begin
      res_d = limit_i;
    end else begin
      res_d = fine_q[TargetBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], sel_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q   <= pp_d;
      s6_q   <= sel_i;
      amt6_q <= amt_i;
      prod_q <= sum_v[PW-1:0];
      s7_q   <= s6_q;
      amt7_q <= amt6_q;
      crs_q  <= wide_v >> {amt7_q[AW-1:5], 5'b0};
      s8_q   <= s7_q;
      amt8_q <= amt7_q;
      fine_q <= crs_q >> amt8_q[4:0];
      s9_q   <= s8_q;
      res_q  <= res_d;
      bad_q  <= s9_q.bad;
    end
  end

  assign valid_o  = vld_q[4];
  assign bad_o    = bad_q;
  assign result_o = res_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for the target calculation core: streams anchor targets through it
// and compares each new target with a bit-exact predictor; depends on atc_pkg and the core
module testbench;

  typedef struct {
    logic [223:0] anchor;
    logic [48:0]  elapsed;
    logic [30:0]  blocks;
  } calc_in_t;

  typedef struct {
    logic [223:0] target;
    logic         bad;
  } calc_out_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [atc_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [atc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [atc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [atc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  asert_target_calculation_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // anchor_word0..3, elapsed_time, blocks_since_anchor
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // result_word0..3
    .m_axis_tdata  (m_axis_tdata),
    // bad_input
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  localparam int STALL_LIMIT = 5000;

  // shadow copy of the configuration
  logic [30:0]  spacing_q;
  logic [31:0]  half_life_q;
  logic [223:0] limit_q;

  calc_out_t target_q[$];
  int        snd_idle = 0;
  int        rcv_idle = 0;
  longint    cyc = 0;
  longint    hold_until = 0;
  int        stall_cnt = 0;
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_bad_seen = 0;

  function automatic calc_out_t predict_target(calc_in_t it);
    calc_out_t r;
    logic signed [63:0] t, d, dabs, d2, shifts, sh;
    logic [63:0] sp_h, mag, q, frac, poly, s;
    logic [16:0] factor;
    logic [1023:0] prod, res, lim;
    logic neg;
    lim = 1024'(limit_q);
    t = {{15{it.elapsed[48]}}, it.elapsed};
    sp_h = 64'(spacing_q) * 64'(it.blocks);
    d = t - $signed(sp_h);
    dabs = (d < 0) ? -d : d;
    r.bad = (it.anchor == '0) || (it.anchor > limit_q) || (spacing_q == '0) ||
            (half_life_q == '0) || (dabs >= $signed(atc_pkg::DRIFT_LIM));
    if (r.bad) begin
      r.target = limit_q;
      return r;
    end
    d2 = d - $signed(64'(spacing_q));
    neg = d2 < 0;
    mag = neg ? -d2 : d2;
    q = (mag << 16) / 64'(half_life_q);
    if (!neg) begin
      shifts = q >> 16;
      frac = q & 64'hFFFF;
    end else if ((q & 64'hFFFF) == 0) begin
      shifts = -$signed(q >> 16);
      frac = 0;
    end else begin
      shifts = -$signed((q >> 16) + 1);
      frac = 64'd65536 - (q & 64'hFFFF);
    end
    // 64-bit wrap matches the original fixed-point arithmetic
    poly = atc_pkg::POLY_C1 * frac + atc_pkg::POLY_C2 * frac * frac +
           atc_pkg::POLY_C3 * frac * frac * frac + atc_pkg::POLY_ROUND;
    factor = atc_pkg::FACTOR_ONE + 17'(poly >> 48);
    prod = 1024'(it.anchor) * 1024'(factor);
    sh = shifts - 16;
    if (sh <= 0) begin
      s = -sh;
      res = (s >= 1024) ? '0 : prod >> s;
    end else if (sh >= 512) begin
      res = lim;
    end else begin
      res = prod << sh;
    end
    if (res == '0) res = 1024'(1);
    else if (res > lim) res = lim;
    r.target = res[223:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [223:0] got, logic [223:0] want);
    n_errors++;
    if (n_errors <= 30)
      $display("mismatch on result %0d, %s: got %h want %h", n_checked, what, got, want);
  endtask

  // result checker, receiver idling and watchdog
  always @(posedge clk_i) begin
    calc_out_t exp_r;
    cyc <= cyc + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      if (target_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, '0);
      end else begin
        exp_r = target_q.pop_front();
        for (int w = 0; w < 4; w++)
          if (m_axis_tdata[w*56 +: 56] !== exp_r.target[w*56 +: 56])
            report_mismatch($sformatf("result_word%0d", w),
                            224'(m_axis_tdata[w*56 +: 56]),
                            224'(exp_r.target[w*56 +: 56]));
        if (m_axis_tuser !== exp_r.bad)
          report_mismatch("bad_input", 224'(m_axis_tuser), 224'(exp_r.bad));
        if (exp_r.bad) n_bad_seen++;
      end
      n_checked++;
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (rst_ni)
      m_axis_tready <= (cyc < hold_until) ? 1'b0 : ($urandom_range(99) >= rcv_idle);
  end

  task automatic send_item(calc_in_t it);
    int gap;
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.blocks, it.elapsed, it.anchor};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    target_q.push_back(predict_target(it));
    n_sent++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    while (target_q.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic cfg_write(atc_pkg::cfg_idx_e idx, logic [55:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      atc_pkg::CFG_SPACING:   spacing_q = v[30:0];
      atc_pkg::CFG_HALF_LIFE: half_life_q = v[31:0];
      atc_pkg::CFG_LIMIT0:    limit_q[55:0] = v;
      atc_pkg::CFG_LIMIT1:    limit_q[111:56] = v;
      atc_pkg::CFG_LIMIT2:    limit_q[167:112] = v;
      atc_pkg::CFG_LIMIT3:    limit_q[223:168] = v;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [30:0] spc, logic [31:0] hl, logic [223:0] lim);
    cfg_write(atc_pkg::CFG_SPACING, 56'(spc));
    cfg_write(atc_pkg::CFG_HALF_LIFE, 56'(hl));
    cfg_write(atc_pkg::CFG_LIMIT0, lim[55:0]);
    cfg_write(atc_pkg::CFG_LIMIT1, lim[111:56]);
    cfg_write(atc_pkg::CFG_LIMIT2, lim[167:112]);
    cfg_write(atc_pkg::CFG_LIMIT3, lim[223:168]);
  endtask

  function automatic logic [223:0] rand_wide();
    logic [223:0] v;
    for (int k = 0; k < 7; k++) v[k*32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic calc_in_t make_item(logic [223:0] a, logic signed [63:0] t,
                                         logic [30:0] h);
    calc_in_t it;
    it.anchor = a;
    it.elapsed = t[48:0];
    it.blocks = h;
    return it;
  endfunction

  // well-formed items sit near the schedule so the exponent path is exercised
  function automatic calc_in_t rand_item();
    calc_in_t it;
    logic [223:0] a;
    logic [63:0] hmax, h, drift;
    logic signed [63:0] t;
    int k;
    if ($urandom_range(99) < 20) begin
      it.anchor = rand_wide();
      it.elapsed = 49'({$urandom, $urandom});
      it.blocks = 31'($urandom);
      return it;
    end
    a = rand_wide() >> $urandom_range(0, 223);
    if (a > limit_q) a = limit_q >> $urandom_range(0, 8);
    if (a == '0 && $urandom_range(9) != 0) a = 1;
    hmax = (spacing_q == 0) ? 64'h7FFFFFFF : (64'd1 << 46) / 64'(spacing_q);
    if (hmax > 64'h7FFFFFFF) hmax = 64'h7FFFFFFF;
    h = {$urandom, $urandom} % (hmax + 1);
    if ($urandom_range(1)) h = h >> $urandom_range(0, 30);
    k = $urandom_range(0, 47);
    drift = {$urandom, $urandom} & ((64'd1 << k) - 1);
    t = $signed(64'(spacing_q) * h) + ($urandom_range(1) ? -$signed(drift) : $signed(drift));
    return make_item(a, t, h[30:0]);
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_item(rand_item());
  endtask

  // extremes of every field and the named corner cases, default configuration
  task automatic test_directed();
    logic signed [63:0] sp;
    sp = 600;
    send_item(make_item({224{1'b1}}, 0, 0));
    send_item(make_item(224'd1, 0, 0));
    send_item(make_item(224'd1, -64'sd100000000, 0));
    send_item(make_item('0, 600, 0));
    send_item(make_item(224'd12345, -(64'sd1 <<< 48), 0));
    send_item(make_item(224'd12345, (64'sd1 <<< 48) - 1, 0));
    send_item(make_item(224'd777, (64'sd1 <<< 47) - 1, 0));
    send_item(make_item(224'd777, (64'sd1 <<< 47), 0));
    send_item(make_item(224'd777, -(64'sd1 <<< 47) + 1, 0));
    send_item(make_item(224'd777, -(64'sd1 <<< 47), 0));
    send_item(make_item(224'hFFFF, 0, 31'h7FFFFFFF));
    // whole and half multiples of the half life, both signs, and a zero exponent
    send_item(make_item(224'hABCDEF, sp * 11 - 64'sd172800 * 3, 10));
    send_item(make_item(224'hABCDEF, sp * 11 + 64'sd172800 * 3, 10));
    send_item(make_item(224'hABCDEF, sp * 11 + 64'sd86400, 10));
    send_item(make_item(224'hABCDEF, sp * 11 - 64'sd86400, 10));
    send_item(make_item(224'hABCDEF, sp * 11, 10));
    send_item(make_item(224'h1 << 200, 64'sd172800 * 60, 0));
    send_item(make_item(rand_wide(), 64'sd1 <<< 46, 0));
    stop_sending();
    wait_drain();
  endtask

  // tight limit: anchors just above and at the limit, zero spacing and half life
  task automatic test_limit_edges();
    logic [223:0] lim;
    lim = rand_wide();
    lim[223:168] = 56'h00000000FFFFFF;
    lim = lim >> 8;
    set_config(31'd600, 32'd172800, lim);
    send_item(make_item(lim, 600, 0));
    send_item(make_item(lim + 1, 600, 0));
    send_item(make_item(lim >> 4, 64'sd172800 * 10, 0));
    stop_sending();
    wait_drain();
    set_config(31'd0, 32'd0, lim);
    send_item(make_item(224'd5, 0, 3));
    stop_sending();
    wait_drain();
    cfg_write(atc_pkg::CFG_SPACING, 56'd600);
    send_item(make_item(224'd5, 0, 3));
    stop_sending();
    wait_drain();
  endtask

  task automatic test_random(logic [30:0] spc, logic [31:0] hl, logic [223:0] lim, int count);
    set_config(spc, hl, lim);
    send_random(count);
    stop_sending();
    wait_drain();
  endtask

  // receiver holds off while the sender keeps offering, then the sender pauses mid-phase
  task automatic test_backpressure();
    set_config(31'd600, 32'd172800, {56'h0000000000FFFF, {168{1'b1}}});
    hold_until = cyc + 400;
    send_random(150);
    stop_sending();
    wait_drain();
    send_random(100);
    stop_sending();
    wait_drain();
  endtask

  initial begin
    spacing_q = 31'd600;
    half_life_q = 32'd172800;
    limit_q = {224{1'b1}};
    snd_idle = 9;
    rcv_idle = 47;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(31'd600, 32'd172800, {224{1'b1}}, 350);
    test_random(31'd1, 32'd1, {224{1'b1}}, 300);
    snd_idle = 47;
    rcv_idle = 9;
    test_limit_edges();
    test_random(31'h7FFFFFFF, 32'hFFFFFFFF, rand_wide() >> 20, 300);
    test_random(31'($urandom_range(1, 5000)), $urandom_range(1, 1000000), rand_wide(), 250);
    snd_idle = 0;
    rcv_idle = 0;
    test_backpressure();
    test_random(31'($urandom), 32'd3600, '0, 80);
    test_random(31'd150, $urandom, rand_wide() >> $urandom_range(0, 100), 400);
    stop_sending();
    repeat (100) @(posedge clk_i);
    $display("ran %0d items across default, extreme, tight-limit and random settings,",
             n_sent);
    $display("%0d results checked, %0d of them rejected inputs", n_checked, n_bad_seen);
    if (n_errors == 0 && target_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, target_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/atc_pkg.sv
src/atc_front.sv
src/atc_div.sv
src/atc_expo.sv
src/atc_scale.sv
src/asert_target_calculation_core.sv
tb/testbench.sv
